### design/fqr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types, codes and the control store of the queue sequencer.
// ----------------------------------------------------------------------------
package fqr_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int VALUE_BITS_DEFAULT = 16;
  localparam int VALUE_W            = 16;
  localparam int POS_W              = 4;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef logic [4:0] step_t;

  typedef enum logic [3:0] {
    J_NEXT, J_ALWAYS, J_OP, J_ZERO, J_FULL, J_EMPTY, J_MATCH, J_PTR_NZ, J_LAST
  } cond_t;

  typedef enum logic {RA_PTR, RA_PTR1} ra_t;
  typedef enum logic {WA_CNT, WA_PTR} wa_t;
  typedef enum logic {WD_VAL, WD_RD} wd_t;
  typedef enum logic [2:0] {P_HOLD, P_ZERO, P_CNT_M1, P_DEC, P_INC} ptr_op_t;
  typedef enum logic [1:0] {C_HOLD, C_INC, C_DEC} cnt_op_t;
  typedef enum logic [2:0] {
    R_NONE, R_VOUT, R_HIT, R_ST_FULL, R_ST_EMPTY, R_ST_ZERO
  } res_op_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    ra_t     ra;
    logic    wr;
    wa_t     wa;
    wd_t     wd;
    ptr_op_t ptr_op;
    cnt_op_t cnt_op;
    res_op_t res_op;
    logic    done;
  } uword_t;

  // program step addresses
  localparam step_t S_DISP   = 5'd0;
  localparam step_t S_PUSH   = 5'd1;
  localparam step_t S_PUSH_F = 5'd2;
  localparam step_t S_PUSH_W = 5'd3;
  localparam step_t S_POP    = 5'd4;
  localparam step_t S_POP_RD = 5'd5;
  localparam step_t S_POP_V  = 5'd6;
  localparam step_t S_FIND   = 5'd7;
  localparam step_t S_F_EMP  = 5'd8;
  localparam step_t S_F_RD   = 5'd9;
  localparam step_t S_F_CMP  = 5'd10;
  localparam step_t S_F_DEC  = 5'd11;
  localparam step_t S_MISS   = 5'd12;
  localparam step_t S_F_HIT  = 5'd13;
  localparam step_t S_REM    = 5'd14;
  localparam step_t S_R_EMP  = 5'd15;
  localparam step_t S_R_OLD  = 5'd16;
  localparam step_t S_R_TOP  = 5'd17;
  localparam step_t S_R_RD   = 5'd18;
  localparam step_t S_R_CMP  = 5'd19;
  localparam step_t S_R_DEC  = 5'd20;
  localparam step_t S_R_MISS = 5'd21;
  localparam step_t S_R_HIT  = 5'd22;
  localparam step_t S_SH_RD  = 5'd23;
  localparam step_t S_SH_WR  = 5'd24;
  localparam step_t S_SH_END = 5'd25;
  localparam step_t S_E_FULL = 5'd26;
  localparam step_t S_E_EMP  = 5'd27;
  localparam step_t S_E_ZERO = 5'd28;

  function automatic step_t dispatch(op_t o);
    step_t s;
    unique case (o)
      OP_PUSH:   s = S_PUSH;
      OP_POP:    s = S_POP;
      OP_FIND:   s = S_FIND;
      OP_REMOVE: s = S_REM;
      default:   s = S_DISP;
    endcase
    return s;
  endfunction

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w.cond   = J_NEXT;
    w.target = S_DISP;
    w.ra     = RA_PTR;
    w.wr     = 1'b0;
    w.wa     = WA_PTR;
    w.wd     = WD_RD;
    w.ptr_op = P_HOLD;
    w.cnt_op = C_HOLD;
    w.res_op = R_NONE;
    w.done   = 1'b0;
    case (s)
      S_DISP: begin
        w.cond = J_OP;
      end
      S_PUSH: begin
        w.cond = J_ZERO; w.target = S_E_ZERO;
      end
      S_PUSH_F: begin
        w.cond = J_FULL; w.target = S_E_FULL;
      end
      S_PUSH_W: begin
        w.wr = 1'b1; w.wa = WA_CNT; w.wd = WD_VAL; w.cnt_op = C_INC; w.done = 1'b1;
      end
      S_POP: begin
        w.cond = J_EMPTY; w.target = S_E_EMP; w.ptr_op = P_ZERO;
      end
      S_POP_RD: begin
        w.cond = J_NEXT;
      end
      S_POP_V: begin
        w.res_op = R_VOUT; w.cond = J_ALWAYS; w.target = S_SH_RD;
      end
      S_FIND: begin
        w.cond = J_ZERO; w.target = S_E_ZERO; w.ptr_op = P_CNT_M1;
      end
      S_F_EMP: begin
        w.cond = J_EMPTY; w.target = S_MISS;
      end
      S_F_RD: begin
        w.cond = J_NEXT;
      end
      S_F_CMP: begin
        w.cond = J_MATCH; w.target = S_F_HIT;
      end
      S_F_DEC: begin
        w.ptr_op = P_DEC; w.cond = J_PTR_NZ; w.target = S_F_RD;
      end
      S_MISS: begin
        w.done = 1'b1;
      end
      S_F_HIT: begin
        w.res_op = R_HIT; w.done = 1'b1;
      end
      S_REM: begin
        w.cond = J_ZERO; w.target = S_E_ZERO; w.ptr_op = P_ZERO;
      end
      S_R_EMP: begin
        w.cond = J_EMPTY; w.target = S_MISS;
      end
      S_R_OLD: begin
        w.cond = J_MATCH; w.target = S_R_HIT;
      end
      S_R_TOP: begin
        w.ptr_op = P_CNT_M1;
      end
      S_R_RD: begin
        w.cond = J_NEXT;
      end
      S_R_CMP: begin
        w.cond = J_MATCH; w.target = S_R_HIT;
      end
      S_R_DEC: begin
        w.ptr_op = P_DEC; w.cond = J_PTR_NZ; w.target = S_R_RD;
      end
      S_R_MISS: begin
        w.done = 1'b1;
      end
      S_R_HIT: begin
        w.res_op = R_HIT; w.cond = J_ALWAYS; w.target = S_SH_RD;
      end
      S_SH_RD: begin
        w.ra = RA_PTR1; w.cond = J_LAST; w.target = S_SH_END;
      end
      S_SH_WR: begin
        w.wr = 1'b1; w.wa = WA_PTR; w.wd = WD_RD; w.ptr_op = P_INC;
        w.cond = J_ALWAYS; w.target = S_SH_RD;
      end
      S_SH_END: begin
        w.cnt_op = C_DEC; w.done = 1'b1;
      end
      S_E_FULL: begin
        w.res_op = R_ST_FULL; w.done = 1'b1;
      end
      S_E_EMP: begin
        w.res_op = R_ST_EMPTY; w.done = 1'b1;
      end
      S_E_ZERO: begin
        w.res_op = R_ST_ZERO; w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### design/fifo_queue_with_remove.sv
`timescale 1ns / 1ps
`default_nettype none
// push checks for a zero tag and a full queue before writing; pop reads the oldest entry and
// shifts the rest down; find scans newest-first; remove checks the oldest entry, then scans
// newest-first, and on a hit shifts the later entries down
// one request at a time; the next is accepted as the strobe ends
// result shows for one cycle on strobe; the receiver cannot stall it
// reset: synchronous, clears count and sequencer; store contents are kept
// ----------------------------------------------------------------------------
// fifo_queue_with_remove
// Bounded FIFO of nonzero tags with find and remove by value, run by a
// microcoded sequencer over an entry store with one write and one read port.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove #(
  parameter int DEPTH      = fqr_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = fqr_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  op,
  input  wire logic [fqr_pkg::VALUE_W-1:0] value,
  output logic                             strobe,
  output logic [fqr_pkg::VALUE_W-1:0]      value_out,
  output logic                             found,
  output logic [fqr_pkg::POS_W-1:0]        position,
  output logic                             is_empty,
  output logic [1:0]                       status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] val_r;
  fqr_pkg::op_t          op_r;
  fqr_pkg::step_t        step;
  logic [AW-1:0]         ptr;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [AW-1:0]         ptr_next;
  fqr_pkg::uword_t       uw;
  logic                  take;
  fqr_pkg::step_t        step_next;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         wa;
  logic [VALUE_BITS-1:0] wd;
  logic [CW:0]           ptr_inc;
  logic [CW-1:0]         pos_full;

  assign uw       = fqr_pkg::ucode(step);
  assign ptr_inc  = (CW + 1)'(ptr) + (CW + 1)'(1);
  assign pos_full = cnt - CW'(1) - CW'(ptr);

  always_comb begin
    unique case (uw.cond)
      fqr_pkg::J_NEXT:   take = 1'b0;
      fqr_pkg::J_ALWAYS: take = 1'b1;
      fqr_pkg::J_OP:     take = 1'b1;
      fqr_pkg::J_ZERO:   take = (val_r == '0);
      fqr_pkg::J_FULL:   take = (cnt == CW'(DEPTH));
      fqr_pkg::J_EMPTY:  take = (cnt == '0);
      fqr_pkg::J_MATCH:  take = (rd_data == val_r);
      fqr_pkg::J_PTR_NZ: take = (ptr != '0);
      fqr_pkg::J_LAST:   take = (ptr_inc >= (CW + 1)'(cnt));
      default:           take = 1'b0;
    endcase
    if (uw.cond == fqr_pkg::J_OP) begin
      step_next = fqr_pkg::dispatch(op_r);
    end else if (take) begin
      step_next = uw.target;
    end else begin
      step_next = step + fqr_pkg::step_t'(1);
    end
  end

  always_comb begin
    unique case (uw.cnt_op)
      fqr_pkg::C_INC: cnt_next = cnt + CW'(1);
      fqr_pkg::C_DEC: cnt_next = cnt - CW'(1);
      default:        cnt_next = cnt;
    endcase
    unique case (uw.ptr_op)
      fqr_pkg::P_ZERO:   ptr_next = '0;
      fqr_pkg::P_CNT_M1: ptr_next = AW'(cnt - CW'(1));
      fqr_pkg::P_DEC:    ptr_next = ptr - AW'(1);
      fqr_pkg::P_INC:    ptr_next = ptr + AW'(1);
      default:           ptr_next = ptr;
    endcase
    ra = (uw.ra == fqr_pkg::RA_PTR1) ? AW'(ptr_inc) : ptr;
    wa = (uw.wa == fqr_pkg::WA_CNT) ? AW'(cnt) : ptr;
    wd = (uw.wd == fqr_pkg::WD_VAL) ? val_r : rd_data;
  end

  // entry store
  always_ff @(posedge clk) begin
    if (busy && uw.wr) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      strobe <= 1'b0;
      step   <= fqr_pkg::S_DISP;
      cnt    <= '0;
    end else begin
      strobe <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy      <= 1'b1;
          step      <= fqr_pkg::S_DISP;
          op_r      <= fqr_pkg::op_t'(op);
          val_r     <= VALUE_BITS'(value);
          value_out <= '0;
          found     <= 1'b0;
          position  <= '0;
          status    <= fqr_pkg::ST_OK;
        end
      end else begin
        step <= step_next;
        ptr  <= ptr_next;
        cnt  <= cnt_next;
        unique case (uw.res_op)
          fqr_pkg::R_VOUT: begin
            value_out <= fqr_pkg::VALUE_W'(rd_data);
          end
          fqr_pkg::R_HIT: begin
            found    <= 1'b1;
            position <= fqr_pkg::POS_W'(pos_full);
          end
          fqr_pkg::R_ST_FULL:  status <= fqr_pkg::ST_FULL;
          fqr_pkg::R_ST_EMPTY: status <= fqr_pkg::ST_EMPTY;
          fqr_pkg::R_ST_ZERO:  status <= fqr_pkg::ST_ZERO;
          default: begin
          end
        endcase
        if (uw.done) begin
          busy     <= 1'b0;
          strobe   <= 1'b1;
          is_empty <= (cnt_next == '0);
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/fqr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqr_checker
// Port-level checks on the queue's command handshake and result strobe.
// ----------------------------------------------------------------------------
module fqr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [15:0] value_out,
  input wire logic       found,
  input wire logic [3:0] position,
  input wire logic [1:0] status
);

  // accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result strobe while busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe longer than one cycle");

  // a flagged request reports no match and no popped item
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    strobe && (status != fqr_pkg::ST_OK) |-> !found && (position == '0) && (value_out == '0))
    else $error("flagged result carries match or value");

endmodule

bind fifo_queue_with_remove fqr_checker u_fqr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .value_out (value_out),
  .found     (found),
  .position  (position),
  .status    (status)
);
`default_nettype wire
